@@ design/rcpc_pkg.sv @@
// Shared types and constants for the RTCP compound datagram checker.
// No dependencies; imported by every module of the block.
package rcpc_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65535;

    localparam logic [7:0] PT_SR  = 8'd200;
    localparam logic [7:0] PT_RR  = 8'd201;
    localparam logic [7:0] PT_BYE = 8'd203;
    localparam logic [7:0] PT_APP = 8'd204;

    localparam logic [1:0] RTCP_VERSION = 2'd2;

    localparam int unsigned SR_BASE_BYTES = 28;
    localparam int unsigned RR_BASE_BYTES = 8;
    localparam int unsigned REPORT_WORDS  = 6;
    localparam int unsigned WORD_BYTES    = 4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOTSUP  = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;

    // one input beat as held in the input register
    typedef struct packed {
        logic [7:0]  byte_value;
        logic [15:0] packet_bytes;
        logic        last_byte;
    } t_beat;

    // decision for one completed RTCP common header
    typedef struct packed {
        logic        notsup;
        logic        corrupt;
        logic        stop;
        logic        bye;
        logic        nho_load;
        logic [18:0] nho;
    } t_hdr_upd;

endpackage

@@ design/rcpc_in_if.sv @@
// Input channel of the RTCP checker: one datagram byte per beat.
// No dependencies.
interface rcpc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [15:0] packet_bytes;
    logic        last_byte;

    modport source (output valid, output byte_value, output packet_bytes,
                    output last_byte, input ready);
    modport sink   (input valid, input byte_value, input packet_bytes,
                    input last_byte, output ready);
endinterface

@@ design/rcpc_out_if.sv @@
// Output channel of the RTCP checker: one verdict beat per datagram.
// No dependencies.
interface rcpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       is_bye;

    modport source (output valid, output status, output is_bye, input ready);
    modport sink   (input valid, input status, input is_bye, output ready);
endinterface

@@ design/rtcp_compound_packet_check.sv @@
// RTCP compound datagram checker: takes one datagram byte per beat and
// returns one verdict (status, is_bye) per datagram, on its last byte.
// Depends on rcpc_pkg, rcpc_in_if, rcpc_out_if, rcpc_in_stage, rcpc_hdr_check.
//
// Accepts one byte every cycle with no gaps between datagrams, except where the stall
// below holds it. A byte passes the input register and is parsed from there against
// the running header walk; the verdict for a datagram is written to the output
// register when its last byte leaves the input register. A verdict waiting in the output
// register stalls input only when another last byte needs to be written.
// The per-byte header test is one 19-bit subtract and compare on the header offset.
module rtcp_compound_packet_check
    import rcpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcpc_in_if.sink     i_in,
    rcpc_out_if.source  o_out
);

    logic        w_in_valid;
    t_beat       w_beat;
    logic        w_take;
    t_hdr_upd    w_upd;

    logic [15:0] r_byte_offset, n_byte_offset;
    logic [18:0] r_nho, n_nho;
    logic [23:0] r_hdr_cap, n_hdr_cap;
    logic        r_first_done, n_first_done;
    logic [1:0]  r_verdict, n_verdict;
    logic        r_bye_seen, n_bye_seen;
    logic        r_walk_stopped, n_walk_stopped;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic        r_is_bye;

    logic [18:0] w_diff;
    logic        w_hdr_hit;
    logic        w_hdr_done;
    logic [18:0] p_nho;
    logic [23:0] p_hdr_cap;
    logic        p_first_done;
    logic [1:0]  p_verdict;
    logic        p_bye_seen;
    logic        p_walk_stopped;
    logic [1:0]  w_status;

    rcpc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_beat  (w_beat)
    );

    rcpc_hdr_check u_hdr_check (
        .i_b0         (r_hdr_cap[23:16]),
        .i_b1         (r_hdr_cap[15:8]),
        .i_lenf       ({r_hdr_cap[7:0], w_beat.byte_value}),
        .i_tot        (w_beat.packet_bytes),
        .i_nho        (r_nho),
        .i_first_done (r_first_done),
        .o_upd        (w_upd)
    );

    // a last byte needs the output register free (or emptying this cycle)
    assign w_take = w_in_valid && (!w_beat.last_byte || !r_out_valid || o_out.ready);

    assign w_diff    = {3'b000, r_byte_offset} - r_nho;
    assign w_hdr_hit = (r_byte_offset < 16'(MAX_PACKET_BYTES)) && !r_walk_stopped &&
                       ({3'b000, r_byte_offset} >= r_nho) && (w_diff < 19'd4);
    assign w_hdr_done = w_hdr_hit && (w_diff[1:0] == 2'd3);

    // state after this byte's header work
    always_comb begin
        p_nho          = r_nho;
        p_hdr_cap      = r_hdr_cap;
        p_first_done   = r_first_done;
        p_verdict      = r_verdict;
        p_bye_seen     = r_bye_seen;
        p_walk_stopped = r_walk_stopped;
        if (w_hdr_hit && !w_hdr_done) begin
            p_hdr_cap = {r_hdr_cap[15:0], w_beat.byte_value};
        end
        if (w_hdr_done) begin
            p_first_done = 1'b1;
            if (w_upd.bye) begin
                p_bye_seen = 1'b1;
            end
            if (w_upd.stop) begin
                p_walk_stopped = 1'b1;
            end
            if (w_upd.nho_load) begin
                p_nho = w_upd.nho;
            end
            if (w_upd.notsup) begin
                p_verdict = ST_NOTSUP;
            end else if (w_upd.corrupt && r_verdict != ST_NOTSUP) begin
                p_verdict = ST_CORRUPT;
            end
        end
    end

    always_comb begin
        w_status = p_verdict;
        if (!p_first_done) begin
            w_status = ST_CORRUPT;
        end else if (w_status != ST_NOTSUP && p_nho != {3'b000, w_beat.packet_bytes}) begin
            w_status = ST_CORRUPT;
        end
        if (r_byte_offset >= 16'(MAX_PACKET_BYTES) ||
            {1'b0, r_byte_offset} + 17'd1 != {1'b0, w_beat.packet_bytes} ||
            {1'b0, w_beat.packet_bytes} > 17'(MAX_PACKET_BYTES)) begin
            w_status = ST_CORRUPT;
        end
    end

    always_comb begin
        n_byte_offset  = r_byte_offset;
        n_nho          = r_nho;
        n_hdr_cap      = r_hdr_cap;
        n_first_done   = r_first_done;
        n_verdict      = r_verdict;
        n_bye_seen     = r_bye_seen;
        n_walk_stopped = r_walk_stopped;
        if (w_take) begin
            if (w_beat.last_byte) begin
                // datagram done: back to the idle parse state
                n_byte_offset  = '0;
                n_nho          = '0;
                n_hdr_cap      = '0;
                n_first_done   = 1'b0;
                n_verdict      = ST_OK;
                n_bye_seen     = 1'b0;
                n_walk_stopped = 1'b0;
            end else begin
                n_nho          = p_nho;
                n_hdr_cap      = p_hdr_cap;
                n_first_done   = p_first_done;
                n_verdict      = p_verdict;
                n_bye_seen     = p_bye_seen;
                n_walk_stopped = p_walk_stopped;
                if (r_byte_offset < 16'(MAX_PACKET_BYTES)) begin
                    n_byte_offset = r_byte_offset + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset  <= '0;
            r_nho          <= '0;
            r_hdr_cap      <= '0;
            r_first_done   <= 1'b0;
            r_verdict      <= ST_OK;
            r_bye_seen     <= 1'b0;
            r_walk_stopped <= 1'b0;
        end else begin
            r_byte_offset  <= n_byte_offset;
            r_nho          <= n_nho;
            r_hdr_cap      <= n_hdr_cap;
            r_first_done   <= n_first_done;
            r_verdict      <= n_verdict;
            r_bye_seen     <= n_bye_seen;
            r_walk_stopped <= n_walk_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && w_beat.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_beat.last_byte) begin
            r_status <= w_status;
            r_is_bye <= p_bye_seen;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_status;
    assign o_out.is_bye = r_is_bye;

    a_verdict_only_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_take && w_beat.last_byte))
        else $error("verdict raised without a last byte");

    a_state_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_beat.last_byte) |=>
        (r_byte_offset == '0 && r_nho == '0 && !r_first_done && r_verdict == ST_OK &&
         !r_bye_seen && !r_walk_stopped))
        else $error("parse state not cleared after datagram end");

    a_notsup_stops_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_verdict == ST_NOTSUP) |-> (r_walk_stopped && r_first_done))
        else $error("unsupported version without walk stop");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_status)))
        else $error("pending verdict lost");

endmodule

@@ design/rcpc_in_stage.sv @@
// Input register of the RTCP checker; holds one byte beat for the parser.
// Depends on rcpc_pkg and rcpc_in_if.
module rcpc_in_stage
    import rcpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcpc_in_if.sink     i_in,
    input  logic        i_take,
    output logic        o_valid,
    output t_beat       o_beat
);

    logic  r_valid;
    t_beat r_beat;

    // a new beat may enter when the register is empty or the held one leaves this cycle
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_beat.byte_value   <= i_in.byte_value;
            r_beat.packet_bytes <= i_in.packet_bytes;
            r_beat.last_byte    <= i_in.last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

@@ design/rcpc_hdr_check.sv @@
// Evaluates one completed RTCP common header (first or following packet).
// Depends on rcpc_pkg.
module rcpc_hdr_check
    import rcpc_pkg::*;
(
    input  logic [7:0]  i_b0,
    input  logic [7:0]  i_b1,
    input  logic [15:0] i_lenf,
    input  logic [15:0] i_tot,
    input  logic [18:0] i_nho,
    input  logic        i_first_done,
    output t_hdr_upd    o_upd
);

    logic [1:0]  w_ver;
    logic        w_pad;
    logic [4:0]  w_cnt;
    logic [18:0] w_bytes;
    logic [18:0] w_tot;
    logic [9:0]  w_rpt;
    logic [18:0] w_sum;

    assign w_ver   = i_b0[7:6];
    assign w_pad   = i_b0[5];
    assign w_cnt   = i_b0[4:0];
    // (length + 1) words, in bytes
    assign w_bytes = {({1'b0, i_lenf} + 17'd1), 2'b00};
    assign w_tot   = {3'b000, i_tot};
    assign w_rpt   = 10'(w_cnt) * 10'(REPORT_WORDS * WORD_BYTES);
    assign w_sum   = i_nho + w_bytes;

    always_comb begin
        o_upd = '0;
        o_upd.nho = w_bytes;
        if (!i_first_done) begin
            o_upd.bye = (i_b1 == PT_BYE);
            if (w_ver != RTCP_VERSION) begin
                o_upd.notsup = 1'b1;
                o_upd.stop   = 1'b1;
            end else begin
                o_upd.nho_load = 1'b1;
                if (w_bytes < w_tot) begin
                    // compound: leading SR/RR with exact report block size and no padding
                    if (i_b1 != PT_SR && i_b1 != PT_RR) begin
                        o_upd.corrupt = 1'b1;
                    end
                    if (i_b1 == PT_SR &&
                        w_bytes != 19'(SR_BASE_BYTES) + 19'(w_rpt)) begin
                        o_upd.corrupt = 1'b1;
                    end
                    if (i_b1 == PT_RR &&
                        w_bytes != 19'(RR_BASE_BYTES) + 19'(w_rpt)) begin
                        o_upd.corrupt = 1'b1;
                    end
                    if (w_pad) begin
                        o_upd.corrupt = 1'b1;
                        o_upd.stop    = 1'b1;
                    end
                end else begin
                    if (w_bytes > w_tot || i_b1 != PT_APP) begin
                        o_upd.corrupt = 1'b1;
                    end
                    o_upd.stop = 1'b1;
                end
            end
        end else begin
            o_upd.nho = w_sum;
            if ({3'b000, i_lenf} > i_nho) begin
                o_upd.corrupt = 1'b1;
            end
            if (w_ver != RTCP_VERSION) begin
                o_upd.corrupt = 1'b1;
                o_upd.stop    = 1'b1;
            end else if (i_b1 == PT_BYE && i_lenf < 16'(w_cnt)) begin
                o_upd.bye     = 1'b1;
                o_upd.corrupt = 1'b1;
                o_upd.stop    = 1'b1;
            end else begin
                o_upd.bye      = (i_b1 == PT_BYE);
                o_upd.nho_load = 1'b1;
                if (w_sum >= w_tot) begin
                    o_upd.stop = 1'b1;
                end
            end
        end
    end

endmodule

@@ tb/rcpc_tb_pkg.sv @@
// Verdict scoreboard for the RTCP compound datagram checker testbench.
// Depends on rcpc_pkg for packet types, status codes and length constants.
package rcpc_tb_pkg;
    import rcpc_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic       is_bye;
    } t_verdict;

    class rtcp_verdict_board;
        // running parse of the datagram in flight
        int unsigned byte_pos;
        bit [18:0]   hdr_start;
        bit [23:0]   hdr_bytes;
        bit          first_seen;
        logic [1:0]  running_status;
        bit          bye_flag;
        bit          walk_done;

        t_verdict    pending[$];
        int unsigned failures;

        function new();
            failures = 0;
            clear();
        endfunction

        function void clear();
            byte_pos       = 0;
            hdr_start      = '0;
            hdr_bytes      = '0;
            first_seen     = 1'b0;
            running_status = ST_OK;
            bye_flag       = 1'b0;
            walk_done      = 1'b0;
        endfunction

        // an unsupported first header is never downgraded to corrupt
        function void flag_corrupt();
            if (running_status != ST_NOTSUP) running_status = ST_CORRUPT;
        endfunction

        function void note_byte(logic [7:0] b, logic [15:0] tot, logic last);
            int unsigned off, lenf, nbytes;
            logic [7:0]  b0, b1;
            logic [1:0]  ver;
            logic [4:0]  cnt;
            t_verdict    v;
            off = byte_pos;
            if (off < MAX_PACKET_BYTES && !walk_done && off >= hdr_start
                && off - hdr_start < 4) begin
                if (off - hdr_start < 3) begin
                    hdr_bytes = {hdr_bytes[15:0], b};
                end else begin
                    b0     = hdr_bytes[23:16];
                    b1     = hdr_bytes[15:8];
                    lenf   = 32'({hdr_bytes[7:0], b});
                    ver    = b0[7:6];
                    cnt    = b0[4:0];
                    nbytes = (lenf + 1) * WORD_BYTES;
                    if (!first_seen) begin
                        first_seen = 1'b1;
                        if (b1 == PT_BYE) bye_flag = 1'b1;
                        if (ver != RTCP_VERSION) begin
                            running_status = ST_NOTSUP;
                            walk_done      = 1'b1;
                        end else begin
                            hdr_start = 19'(nbytes);
                            if (nbytes < tot) begin
                                if (b1 != PT_SR && b1 != PT_RR) flag_corrupt();
                                if (b1 == PT_SR && nbytes !=
                                    SR_BASE_BYTES + cnt * REPORT_WORDS * WORD_BYTES)
                                    flag_corrupt();
                                if (b1 == PT_RR && nbytes !=
                                    RR_BASE_BYTES + cnt * REPORT_WORDS * WORD_BYTES)
                                    flag_corrupt();
                                if (b0[5]) begin
                                    flag_corrupt();
                                    walk_done = 1'b1;
                                end
                            end else begin
                                if (nbytes > tot || b1 != PT_APP) flag_corrupt();
                                walk_done = 1'b1;
                            end
                        end
                    end else begin
                        if (lenf > hdr_start) flag_corrupt();
                        if (ver != RTCP_VERSION) begin
                            flag_corrupt();
                            walk_done = 1'b1;
                        end else if (b1 == PT_BYE && lenf < cnt) begin
                            bye_flag = 1'b1;
                            flag_corrupt();
                            walk_done = 1'b1;
                        end else begin
                            if (b1 == PT_BYE) bye_flag = 1'b1;
                            hdr_start = 19'(hdr_start + nbytes);   // wraps at 19 bits
                            if (hdr_start >= tot) walk_done = 1'b1;
                        end
                    end
                end
            end

            if (!last) begin
                if (off < MAX_PACKET_BYTES) byte_pos = off + 1;
                return;
            end

            v.status = running_status;
            if (!first_seen)
                v.status = ST_CORRUPT;
            else if (v.status != ST_NOTSUP && hdr_start != tot)
                v.status = ST_CORRUPT;
            if (off >= MAX_PACKET_BYTES || off + 1 != tot)
                v.status = ST_CORRUPT;
            v.is_bye = bye_flag;
            pending.push_back(v);
            clear();
        endfunction

        function void check_verdict(logic [1:0] status, logic is_bye);
            t_verdict want;
            if (pending.size() == 0) begin
                $error("verdict with no datagram outstanding: status %0d, is_bye %0d",
                       status, is_bye);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                failures++;
            end
            if (is_bye !== want.is_bye) begin
                $error("is_bye mismatch: expected %0d, actual %0d", want.is_bye, is_bye);
                failures++;
            end
        endfunction
    endclass

endpackage

@@ tb/testbench.sv @@
// Top-level testbench: drives RTCP datagrams byte by byte into the checker and
// compares every verdict with the scoreboard. Depends on rcpc_pkg, rcpc_tb_pkg,
// rcpc_in_if, rcpc_out_if and rtcp_compound_packet_check.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpc_pkg::*;
    import rcpc_tb_pkg::*;

    localparam logic [7:0] PT_SDES = 8'd202;

    typedef enum int {
        DG_CLEAN, DG_SINGLE, DG_FLIP_BIT, DG_TRUNCATE, DG_EXTEND, DG_FIRST_VERSION,
        DG_FIRST_PAD, DG_NEXT_VERSION, DG_BYE_SHORT, DG_HUGE_LENGTH, DG_WRONG_TOTAL,
        DG_WANDERING_TOTAL, DG_NOISE
    } t_dgram_kind;

    logic i_clk;
    logic i_rst_n;

    rcpc_in_if  in_bus();
    rcpc_out_if out_bus();

    rtcp_compound_packet_check u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    rtcp_verdict_board board = new();

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned beats_sent     = 0;
    int unsigned first_len      = 0;
    logic [7:0]  dgram[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("rtcp_compound_packet_check verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready)
                board.note_byte(in_bus.byte_value, in_bus.packet_bytes, in_bus.last_byte);
            if (out_bus.valid && out_bus.ready)
                board.check_verdict(out_bus.status, out_bus.is_bye);
        end
    end

    // header word plus body_words of random payload; lenf may lie about the body
    function automatic void put_packet(int unsigned ver, bit pad, int unsigned cnt,
                                       logic [7:0] pt, int unsigned lenf,
                                       int unsigned body_words);
        dgram.push_back({ver[1:0], pad, cnt[4:0]});
        dgram.push_back(pt);
        dgram.push_back(lenf[15:8]);
        dgram.push_back(lenf[7:0]);
        repeat (body_words * 4) dgram.push_back(8'($urandom));
    endfunction

    // SR or RR with exact report length, then one to three further packets
    function automatic void build_compound();
        int unsigned cnt, lenf;
        dgram.delete();
        cnt = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) begin
            lenf = 6 + 6 * cnt;
            put_packet(2, 0, cnt, PT_SR, lenf, lenf);
        end else begin
            lenf = 1 + 6 * cnt;
            put_packet(2, 0, cnt, PT_RR, lenf, lenf);
        end
        first_len = dgram.size();
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
                0: begin
                    lenf = $urandom_range(0, 4);
                    put_packet(2, 0, $urandom_range(0, 31), PT_SDES, lenf, lenf);
                end
                1: begin
                    cnt  = $urandom_range(0, 4);
                    lenf = $urandom_range(cnt, cnt + 2);
                    put_packet(2, 0, cnt, PT_BYE, lenf, lenf);
                end
                2: begin
                    lenf = $urandom_range(0, 4);
                    put_packet(2, 0, $urandom_range(0, 31), PT_APP, lenf, lenf);
                end
                default: begin
                    lenf = $urandom_range(0, 4);
                    put_packet(2, 1'($urandom_range(0, 1)), $urandom_range(0, 31),
                               8'($urandom), lenf, lenf);
                end
            endcase
        end
    endfunction

    task automatic send_beat(logic [7:0] b, logic [15:0] tot, logic last);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.byte_value   <= b;
        in_bus.packet_bytes <= tot;
        in_bus.last_byte    <= last;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    task automatic send_dgram(logic [15:0] tot, bit wander);
        logic [15:0] carried;
        foreach (dgram[i]) begin
            carried = (wander && $urandom_range(0, 5) == 0) ? 16'($urandom) : tot;
            send_beat(dgram[i], carried, i == dgram.size() - 1);
        end
        beats_sent += dgram.size();
        dgram.delete();
    endtask

    // hold input off until every verdict is back
    task automatic drain_results();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending.size() != 0);
    endtask

    task automatic send_random_datagram();
        t_dgram_kind kind;
        int unsigned orig, idx, v, lenf;
        logic [15:0] tot;
        kind = ($urandom_range(0, 99) < 60) ? DG_CLEAN
                                            : t_dgram_kind'($urandom_range(1, 12));
        build_compound();
        orig = dgram.size();
        case (kind)
            DG_SINGLE: begin
                dgram.delete();
                lenf = $urandom_range(0, 5);
                put_packet(2, 0, $urandom_range(0, 31),
                           ($urandom_range(0, 2) != 0) ? PT_APP : 8'($urandom), lenf, lenf);
            end
            DG_FLIP_BIT: begin
                idx = $urandom_range(0, dgram.size() - 1);
                dgram[idx] = dgram[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            DG_TRUNCATE: repeat ($urandom_range(1, dgram.size() - 1)) void'(dgram.pop_back());
            DG_EXTEND:   repeat ($urandom_range(1, 8)) dgram.push_back(8'($urandom));
            DG_FIRST_VERSION: begin
                v = $urandom_range(0, 2);
                if (v == 2) v = 3;
                dgram[0] = {v[1:0], dgram[0][5:0]};
            end
            DG_FIRST_PAD: dgram[0] = dgram[0] | 8'h20;
            DG_NEXT_VERSION: begin
                v = $urandom_range(0, 2);
                if (v == 2) v = 3;
                dgram[first_len] = {v[1:0], dgram[first_len][5:0]};
            end
            DG_BYE_SHORT: begin
                lenf = 32'({dgram[first_len + 2], dgram[first_len + 3]});
                if (lenf < 31) begin
                    dgram[first_len + 1] = PT_BYE;
                    dgram[first_len] = {2'b10, 1'b0, 5'($urandom_range(lenf + 1, 31))};
                end
            end
            DG_HUGE_LENGTH: dgram[first_len + 2] = 8'($urandom_range(128, 255));
            DG_NOISE: begin
                dgram.delete();
                repeat ($urandom_range(1, 40)) dgram.push_back(8'($urandom));
            end
            default: ;
        endcase
        tot = 16'(dgram.size());
        if ((kind == DG_TRUNCATE || kind == DG_EXTEND) && $urandom_range(0, 1))
            tot = 16'(orig);
        if (kind == DG_WRONG_TOTAL)
            tot = $urandom_range(0, 1) ? 16'($urandom) : tot + 16'($urandom_range(1, 8));
        send_dgram(tot, kind == DG_WANDERING_TOTAL);
    endtask

    initial begin
        int unsigned gap_by_phase[4];
        int unsigned stall_by_phase[4];
        int unsigned start_beats, dgrams;
        logic [15:0] tot;

        gap_by_phase        = '{0, 82, 0, 32};
        stall_by_phase      = '{0, 0, 82, 32};
        i_rst_n             <= 1'b0;
        in_bus.valid        <= 1'b0;
        in_bus.byte_value   <= '0;
        in_bus.packet_bytes <= '0;
        in_bus.last_byte    <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // well-formed SR without reports, then SDES
        put_packet(2, 0, 0, PT_SR, 6, 6);
        put_packet(2, 0, 1, PT_SDES, 2, 2);
        send_dgram(16'(dgram.size()), 0);
        // RR with the most report blocks, BYE whose count equals its length
        put_packet(2, 0, 31, PT_RR, 187, 187);
        put_packet(2, 0, 31, PT_BYE, 31, 31);
        send_dgram(16'(dgram.size()), 0);
        // lone APP of one word; lone RR; lone BYE
        put_packet(2, 0, 0, PT_APP, 0, 0);
        send_dgram(16'(dgram.size()), 0);
        put_packet(2, 0, 0, PT_RR, 1, 1);
        send_dgram(16'(dgram.size()), 0);
        put_packet(2, 0, 1, PT_BYE, 1, 1);
        send_dgram(16'(dgram.size()), 0);
        // unsupported version: all zeros, all ones, then with a bad byte count
        repeat (8) dgram.push_back(8'h00);
        send_dgram(8, 0);
        repeat (8) dgram.push_back(8'hFF);
        send_dgram(8, 0);
        put_packet(1, 0, 0, PT_SR, 6, 6);
        put_packet(2, 0, 0, PT_APP, 0, 0);
        send_dgram(16'(dgram.size() + 1), 0);
        // padded first packet
        put_packet(2, 1, 0, PT_RR, 1, 1);
        put_packet(2, 0, 0, PT_APP, 1, 1);
        send_dgram(16'(dgram.size()), 0);
        // SR length disagrees with its count; compound led by APP
        put_packet(2, 0, 2, PT_SR, 6, 6);
        put_packet(2, 0, 0, PT_APP, 1, 1);
        send_dgram(16'(dgram.size()), 0);
        put_packet(2, 0, 0, PT_APP, 1, 1);
        put_packet(2, 0, 0, PT_APP, 0, 0);
        send_dgram(16'(dgram.size()), 0);
        // shorter than one header, then a lone header; packet_bytes at both extremes
        dgram.push_back(8'h80);
        send_dgram(0, 0);
        repeat (3) dgram.push_back(8'($urandom));
        send_dgram(3, 0);
        put_packet(2, 0, 0, PT_APP, 0, 0);
        send_dgram(16'hFFFF, 0);
        // second header cut off by the end of the datagram
        put_packet(2, 0, 0, PT_RR, 1, 1);
        dgram.push_back(8'h81);
        dgram.push_back(PT_SDES);
        send_dgram(16'(dgram.size()), 0);
        // bad version in a following header; BYE count above its length
        put_packet(2, 0, 0, PT_RR, 1, 1);
        put_packet(1, 0, 0, PT_SDES, 0, 0);
        send_dgram(16'(dgram.size()), 0);
        put_packet(2, 0, 0, PT_RR, 1, 1);
        put_packet(2, 0, 3, PT_BYE, 2, 2);
        send_dgram(16'(dgram.size()), 0);
        // following length field far beyond its own offset
        put_packet(2, 0, 0, PT_RR, 1, 1);
        put_packet(2, 0, 0, PT_APP, 16'hFFFF, 1);
        send_dgram(16'(dgram.size()), 0);
        // bytes left over after the walk has summed to packet_bytes
        put_packet(2, 0, 0, PT_RR, 1, 1);
        put_packet(2, 0, 0, PT_APP, 0, 0);
        tot = 16'(dgram.size());
        repeat (4) dgram.push_back(8'($urandom));
        send_dgram(tot, 0);
        // packet_bytes changing within the datagram
        build_compound();
        send_dgram(16'(dgram.size()), 1);
        // largest well-formed datagram, then an overlong one past the offset limit
        put_packet(2, 0, 0, PT_APP, 16382, 16382);
        send_dgram(16'(dgram.size()), 0);
        put_packet(2, 0, 0, PT_APP, 16382, 16382);
        repeat (5) dgram.push_back(8'($urandom));
        send_dgram(16'hFFFF, 0);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            send_gap_pct   = gap_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            start_beats    = beats_sent;
            dgrams         = 0;
            while (beats_sent - start_beats < 500 || dgrams < 16) begin
                send_random_datagram();
                dgrams++;
                if (phase == 1 && dgrams == 8) drain_results();
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (board.failures == 0 && board.pending.size() == 0)
            $display("rtcp_compound_packet_check verification clean");
        else
            $display("rtcp_compound_packet_check verification failed");
        $finish;
    end

endmodule
